FILE: sv/ini_lt_pkg.sv
// shared types, codes and character helpers for the ini line tokenizer
package ini_lt_pkg;

    // default length limits
    localparam int NAME_MAX_DEF  = 255;
    localparam int VALUE_MAX_DEF = 8191;

    // parse phase codes
    localparam logic [3:0] PH_LINE_START = 4'd0;
    localparam logic [3:0] PH_SEC_FIRST  = 4'd1;
    localparam logic [3:0] PH_SEC_NAME   = 4'd2;
    localparam logic [3:0] PH_PAR_NAME   = 4'd3;
    localparam logic [3:0] PH_PRE_EQ     = 4'd4;
    localparam logic [3:0] PH_PRE_VAL    = 4'd5;
    localparam logic [3:0] PH_UVAL       = 4'd6;
    localparam logic [3:0] PH_QVAL       = 4'd7;
    localparam logic [3:0] PH_LINE_END   = 4'd8;
    localparam logic [3:0] PH_COMMENT    = 4'd9;

    // role codes
    localparam logic [1:0] ROLE_NONE    = 2'd0;
    localparam logic [1:0] ROLE_SECTION = 2'd1;
    localparam logic [1:0] ROLE_PARAM   = 2'd2;
    localparam logic [1:0] ROLE_VALUE   = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_NAME_LONG   = 4'd1;
    localparam logic [3:0] ERR_VALUE_LONG  = 4'd2;
    localparam logic [3:0] ERR_EMPTY_VALUE = 4'd3;
    localparam logic [3:0] ERR_QUOTE       = 4'd4;
    localparam logic [3:0] ERR_NO_SECTION  = 4'd5;
    localparam logic [3:0] ERR_NO_EQUALS   = 4'd6;
    localparam logic [3:0] ERR_EMPTY_SEC   = 4'd7;
    localparam logic [3:0] ERR_NO_BRACKET  = 4'd8;
    localparam logic [3:0] ERR_EOL         = 4'd9;

    // character constants
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // one classified byte
    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] role;
        logic       name_first;
        logic       param_complete;
        logic       line_done;
        logic [3:0] error_code;
    } t_result;

    // letters, digits and underscore
    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

FILE: sv/ini_lt_if.sv
// request channels for the ini line tokenizer: text bytes in, classified bytes out
interface ini_lt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ini_lt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] role;
    logic       name_first;
    logic       param_complete;
    logic       line_done;
    logic [3:0] error_code;

    modport source (
        output valid, output char_out, output role, output name_first,
        output param_complete, output line_done, output error_code, input ready
    );
    modport sink (
        input valid, input char_out, input role, input name_first,
        input param_complete, input line_done, input error_code, output ready
    );
endinterface

FILE: sv/ini_lt_core.sv
// parser state and per-byte classification logic
module ini_lt_core #(
    parameter int NAME_MAX  = ini_lt_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = ini_lt_pkg::VALUE_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output ini_lt_pkg::t_result  o_result
);

    localparam int NW = $clog2(NAME_MAX + 1);
    localparam int VW = $clog2(VALUE_MAX + 1);

    logic [3:0]    r_phase, n_phase;
    logic [NW-1:0] r_name_len, n_name_len;
    logic [VW-1:0] r_val_len, n_val_len;
    logic          r_esc, n_esc;
    logic          r_sec, n_sec;
    logic [3:0]    r_err, n_err;

    logic [NW:0]   w_name_inc;
    logic [VW:0]   w_val_inc;
    logic          w_name_over;
    logic          w_val_over;

    logic [7:0]    w_ch;
    logic [1:0]    w_role;
    logic          w_nstart;
    logic          w_pc;
    logic          w_done;

    // length counters and overflow checks
    assign w_name_inc  = {1'b0, r_name_len} + (NW+1)'(1);
    assign w_val_inc   = {1'b0, r_val_len} + (VW+1)'(1);
    assign w_name_over = w_name_inc > (NW+1)'(NAME_MAX);
    assign w_val_over  = w_val_inc > (VW+1)'(VALUE_MAX);

    // next state and result for one byte
    always_comb begin
        n_phase    = r_phase;
        n_name_len = r_name_len;
        n_val_len  = r_val_len;
        n_esc      = r_esc;
        n_sec      = r_sec;
        n_err      = r_err;
        w_ch       = 8'd0;
        w_role     = ini_lt_pkg::ROLE_NONE;
        w_nstart   = 1'b0;
        w_pc       = 1'b0;
        w_done     = 1'b0;

        if (r_err == ini_lt_pkg::ERR_NONE) begin
            unique case (r_phase)
                ini_lt_pkg::PH_LINE_START, ini_lt_pkg::PH_LINE_END: begin
                    if (ini_lt_pkg::is_blank(i_byte)) begin
                        n_phase = r_phase;
                    end else if (r_phase == ini_lt_pkg::PH_LINE_START &&
                                 i_byte == ini_lt_pkg::CH_LBRACK) begin
                        n_phase = ini_lt_pkg::PH_SEC_FIRST;
                    end else if (r_phase == ini_lt_pkg::PH_LINE_START &&
                                 ini_lt_pkg::is_name_char(i_byte)) begin
                        w_ch       = i_byte;
                        w_role     = ini_lt_pkg::ROLE_PARAM;
                        w_nstart   = 1'b1;
                        n_name_len = NW'(1);
                        n_phase    = ini_lt_pkg::PH_PAR_NAME;
                    end else if (i_byte == ini_lt_pkg::CH_HASH) begin
                        n_phase = ini_lt_pkg::PH_COMMENT;
                    end else if (ini_lt_pkg::is_eol(i_byte)) begin
                        w_done = 1'b1;
                    end else begin
                        n_err = ini_lt_pkg::ERR_EOL;
                    end
                end
                ini_lt_pkg::PH_SEC_FIRST: begin
                    if (ini_lt_pkg::is_name_char(i_byte)) begin
                        w_ch       = i_byte;
                        w_role     = ini_lt_pkg::ROLE_SECTION;
                        w_nstart   = 1'b1;
                        n_name_len = NW'(1);
                        n_phase    = ini_lt_pkg::PH_SEC_NAME;
                    end else begin
                        n_err = ini_lt_pkg::ERR_EMPTY_SEC;
                    end
                end
                ini_lt_pkg::PH_SEC_NAME: begin
                    if (ini_lt_pkg::is_name_char(i_byte)) begin
                        n_name_len = w_name_inc[NW-1:0];
                        if (w_name_over) begin
                            n_err = ini_lt_pkg::ERR_NAME_LONG;
                        end else begin
                            w_ch   = i_byte;
                            w_role = ini_lt_pkg::ROLE_SECTION;
                        end
                    end else if (i_byte == ini_lt_pkg::CH_RBRACK) begin
                        n_sec   = 1'b1;
                        n_phase = ini_lt_pkg::PH_LINE_END;
                    end else begin
                        n_err = ini_lt_pkg::ERR_NO_BRACKET;
                    end
                end
                ini_lt_pkg::PH_PAR_NAME: begin
                    if (ini_lt_pkg::is_name_char(i_byte)) begin
                        n_name_len = w_name_inc[NW-1:0];
                        if (w_name_over) begin
                            n_err = ini_lt_pkg::ERR_NAME_LONG;
                        end else begin
                            w_ch   = i_byte;
                            w_role = ini_lt_pkg::ROLE_PARAM;
                        end
                    end else if (!r_sec) begin
                        n_err = ini_lt_pkg::ERR_NO_SECTION;
                    end else if (ini_lt_pkg::is_blank(i_byte)) begin
                        n_phase = ini_lt_pkg::PH_PRE_EQ;
                    end else if (i_byte == ini_lt_pkg::CH_EQUALS) begin
                        n_phase = ini_lt_pkg::PH_PRE_VAL;
                    end else begin
                        n_err = ini_lt_pkg::ERR_NO_EQUALS;
                    end
                end
                ini_lt_pkg::PH_PRE_EQ: begin
                    if (ini_lt_pkg::is_blank(i_byte)) begin
                        n_phase = r_phase;
                    end else if (i_byte == ini_lt_pkg::CH_EQUALS) begin
                        n_phase = ini_lt_pkg::PH_PRE_VAL;
                    end else begin
                        n_err = ini_lt_pkg::ERR_NO_EQUALS;
                    end
                end
                ini_lt_pkg::PH_PRE_VAL: begin
                    // a first value byte is not checked for overflow; VALUE_MAX must be at least one, not enforced here
                    if (ini_lt_pkg::is_blank(i_byte)) begin
                        n_phase = r_phase;
                    end else if (i_byte == ini_lt_pkg::CH_QUOTE) begin
                        n_val_len = VW'(1);
                        n_esc     = 1'b0;
                        n_phase   = ini_lt_pkg::PH_QVAL;
                    end else if (i_byte == ini_lt_pkg::CH_HASH ||
                                 ini_lt_pkg::is_eol(i_byte)) begin
                        n_err = ini_lt_pkg::ERR_EMPTY_VALUE;
                    end else begin
                        n_val_len = VW'(1);
                        w_ch      = i_byte;
                        w_role    = ini_lt_pkg::ROLE_VALUE;
                        n_phase   = ini_lt_pkg::PH_UVAL;
                    end
                end
                ini_lt_pkg::PH_UVAL: begin
                    if (ini_lt_pkg::is_blank(i_byte)) begin
                        w_pc    = 1'b1;
                        n_phase = ini_lt_pkg::PH_LINE_END;
                    end else if (i_byte == ini_lt_pkg::CH_HASH) begin
                        w_pc    = 1'b1;
                        n_phase = ini_lt_pkg::PH_COMMENT;
                    end else if (ini_lt_pkg::is_eol(i_byte)) begin
                        w_pc   = 1'b1;
                        w_done = 1'b1;
                    end else if (i_byte == ini_lt_pkg::CH_QUOTE) begin
                        w_pc  = 1'b1;
                        n_err = ini_lt_pkg::ERR_EOL;
                    end else begin
                        n_val_len = w_val_inc[VW-1:0];
                        if (w_val_over) begin
                            n_err = ini_lt_pkg::ERR_VALUE_LONG;
                        end else begin
                            w_ch   = i_byte;
                            w_role = ini_lt_pkg::ROLE_VALUE;
                        end
                    end
                end
                ini_lt_pkg::PH_QVAL: begin
                    if (r_esc) begin
                        n_esc     = 1'b0;
                        n_val_len = w_val_inc[VW-1:0];
                        if (w_val_over) begin
                            n_err = ini_lt_pkg::ERR_VALUE_LONG;
                        end else begin
                            w_ch   = i_byte;
                            w_role = ini_lt_pkg::ROLE_VALUE;
                        end
                    end else if (i_byte == ini_lt_pkg::CH_QUOTE) begin
                        w_pc    = 1'b1;
                        n_phase = ini_lt_pkg::PH_LINE_END;
                    end else if (ini_lt_pkg::is_eol(i_byte)) begin
                        n_err = ini_lt_pkg::ERR_QUOTE;
                    end else begin
                        n_val_len = w_val_inc[VW-1:0];
                        if (w_val_over) begin
                            n_err = ini_lt_pkg::ERR_VALUE_LONG;
                        end else if (i_byte == ini_lt_pkg::CH_BSLASH) begin
                            n_esc = 1'b1;
                        end else begin
                            w_ch   = i_byte;
                            w_role = ini_lt_pkg::ROLE_VALUE;
                        end
                    end
                end
                ini_lt_pkg::PH_COMMENT: begin
                    if (ini_lt_pkg::is_eol(i_byte)) begin
                        w_done = 1'b1;
                    end
                end
                default: begin
                    n_err = ini_lt_pkg::ERR_EOL;
                end
            endcase

            // a finished line starts over
            if (w_done) begin
                n_phase    = ini_lt_pkg::PH_LINE_START;
                n_name_len = '0;
                n_val_len  = '0;
                n_esc      = 1'b0;
            end

            // end of buffer before the line has ended
            if (n_err == ini_lt_pkg::ERR_NONE && i_last && !w_done) begin
                unique case (n_phase)
                    ini_lt_pkg::PH_SEC_FIRST: n_err = ini_lt_pkg::ERR_EMPTY_SEC;
                    ini_lt_pkg::PH_SEC_NAME:  n_err = ini_lt_pkg::ERR_NO_BRACKET;
                    ini_lt_pkg::PH_PAR_NAME: begin
                        n_err = n_sec ? ini_lt_pkg::ERR_NO_EQUALS
                                      : ini_lt_pkg::ERR_NO_SECTION;
                    end
                    ini_lt_pkg::PH_PRE_EQ:    n_err = ini_lt_pkg::ERR_NO_EQUALS;
                    ini_lt_pkg::PH_PRE_VAL:   n_err = ini_lt_pkg::ERR_EMPTY_VALUE;
                    ini_lt_pkg::PH_UVAL: begin
                        w_pc  = 1'b1;
                        n_err = ini_lt_pkg::ERR_EOL;
                    end
                    ini_lt_pkg::PH_QVAL:      n_err = ini_lt_pkg::ERR_QUOTE;
                    default:                  n_err = ini_lt_pkg::ERR_EOL;
                endcase
            end
        end
    end

    // result of the current byte
    assign o_result.char_out       = w_ch;
    assign o_result.role           = w_role;
    assign o_result.name_first     = w_nstart;
    assign o_result.param_complete = w_pc;
    assign o_result.line_done      = w_done;
    assign o_result.error_code     = n_err;

    // parser state, updated when a byte moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ini_lt_pkg::PH_LINE_START;
            r_name_len <= '0;
            r_val_len  <= '0;
            r_esc      <= 1'b0;
            r_sec      <= 1'b0;
            r_err      <= ini_lt_pkg::ERR_NONE;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_name_len <= n_name_len;
            r_val_len  <= n_val_len;
            r_esc      <= n_esc;
            r_sec      <= n_sec;
            r_err      <= n_err;
        end
    end

endmodule

FILE: sv/ini_line_tokenizer.sv
// top level of the ini line tokenizer: input register, parser core, result register
// an accepted byte is held in the input register, then its result is held in the result register
// throughput: one byte per cycle while the result channel is not stalled
// reset: synchronous active-low; both stages empty, parser at line start, no section,
// no error; an error code stays held on every later result until reset
module ini_line_tokenizer #(
    parameter int NAME_MAX  = ini_lt_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = ini_lt_pkg::VALUE_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ini_lt_in_if.sink           i_in,
    ini_lt_out_if.source        o_out
);

    logic                r_in_valid, n_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid, n_out_valid;
    ini_lt_pkg::t_result r_out;
    ini_lt_pkg::t_result w_result;
    logic                w_adv;
    logic                w_take;

    // stage handshakes
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = w_take ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = w_adv ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    // parser core
    ini_lt_core #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in.byte_in;
            r_in_last <= i_in.last_byte;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.char_out       = r_out.char_out;
    assign o_out.role           = r_out.role;
    assign o_out.name_first     = r_out.name_first;
    assign o_out.param_complete = r_out.param_complete;
    assign o_out.line_done      = r_out.line_done;
    assign o_out.error_code     = r_out.error_code;

endmodule
